>>> sv/pcg32_random_engine_top_assert.svh
// Assertion macros for the PCG32 engine sequencer RTL.
`ifndef PCG32_RANDOM_ENGINE_TOP_ASSERT_SVH
`define PCG32_RANDOM_ENGINE_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PCG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define PCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/pcg_pkg.sv
// Shared types and constants of the PCG32 engine.
`default_nettype none
package pcg_pkg;
    localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;
    localparam logic [11:0] COIN_MASK = 12'h800;
    localparam int unsigned ROT_SHIFT = 59;
    localparam int unsigned XS_OUT_SHIFT = 27;
    localparam int unsigned XS_IN_SHIFT = 18;

    typedef enum logic [2:0] {
        ACT_RESEED = 3'd0, ACT_DRAW32 = 3'd1, ACT_BND32 = 3'd2, ACT_DRAW64 = 3'd3,
        ACT_BND64 = 3'd4, ACT_COIN = 3'd5, ACT_ADVANCE = 3'd6, ACT_NONE = 3'd7
    } t_action;

    localparam logic CFG_SEED = 1'b0;
    localparam logic CFG_STREAM = 1'b1;

    // Request to the shared multiply-add unit: result = a * b + c.
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } t_mac_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_mac_rsp;

    // Request to the shared remainder unit: result = num % den.
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_mod_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_mod_rsp;

    function automatic logic [31:0] xsh_rr(input logic [63:0] old);
        logic [63:0] t;
        logic [31:0] x;
        logic [4:0]  rot;
        begin
            t   = ((old >> XS_IN_SHIFT) ^ old) >> XS_OUT_SHIFT;
            x   = t[31:0];
            rot = 5'(old >> ROT_SHIFT);
            xsh_rr = (x >> rot) | (x << ((6'd32 - {1'b0, rot}) & 6'd31));
        end
    endfunction
endpackage
`default_nettype wire

>>> sv/pcg_mac.sv
// Shared 64-bit multiply-add unit, three 32x32 partial products, one per cycle.
`default_nettype none
module pcg_mac
    import pcg_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mac_req i_req,
    output t_mac_rsp      o_rsp
);
    logic [63:0] r_a, r_b, r_acc, n_acc;
    logic [2:0]  r_step;
    logic        r_busy;
    logic [31:0] w_x, w_y;
    logic [63:0] w_pp;

    // Only the low 64 bits matter: a_lo*b_lo, a_lo*b_hi<<32, a_hi*b_lo<<32.
    always_comb begin
        case (r_step)
            3'd0:    begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
            3'd1:    begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
            default: begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
        endcase
        w_pp = 64'(w_x) * 64'(w_y);
        n_acc = (r_step == 3'd0) ? r_acc + w_pp : r_acc + {w_pp[31:0], 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 3'd0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= 3'd0;
        end else if (r_busy) begin
            r_step <= r_step + 3'd1;
            if (r_step == 3'd2) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= i_req.c;
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_rsp.done = !r_busy && (r_step == 3'd3);
    assign o_rsp.res  = r_acc;
endmodule
`default_nettype wire

>>> sv/pcg_mod.sv
// Shared restoring remainder unit, one quotient bit per cycle.
`default_nettype none
module pcg_mod
    import pcg_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mod_req i_req,
    output t_mod_rsp      o_rsp
);
    logic [63:0] r_num, r_den, r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] w_sh, w_diff;

    always_comb begin
        w_sh   = {r_rem, r_num[63]};
        w_diff = w_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= 64'd0;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], 1'b0};
            r_rem <= w_diff[64] ? w_sh[63:0] : w_diff[63:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_rem;
endmodule
`default_nettype wire

>>> sv/pcg_seq.sv
// Command sequencer of the PCG32 engine: drives the shared units per action.
`default_nettype none
`include "pcg32_random_engine_top_assert.svh"
module pcg_seq
    import pcg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_ready,
    input  wire logic [2:0]  i_action,
    input  wire logic [63:0] i_operand,
    input  wire logic [63:0] i_seed,
    input  wire logic [63:0] i_inc,
    output t_mac_req         o_mac_req,
    input  wire t_mac_rsp    i_mac_rsp,
    output t_mod_req         o_mod_req,
    input  wire t_mod_rsp    i_mod_rsp,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [63:0]      o_res_value
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_STEP = 7'b0000010, S_THR  = 7'b0000100,
        S_RMOD = 7'b0001000, S_ADV  = 7'b0010000, S_ADVF = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    // Multiply-add jobs: LCG step, or one of the advance products.
    typedef enum logic [2:0] {
        J_STEP, J_AM, J_AP, J_CP, J_CM, J_FIN
    } t_job;

    t_state      r_state;
    t_action     r_act;
    t_job        r_job;
    logic        r_wait, r_modwait;
    logic [1:0]  r_draws;   // draws left in current sample
    logic        r_reseed_ph;
    logic [63:0] r_lcg, r_bound, r_thr, r_samp, r_val;
    logic [63:0] r_dlt, r_cm, r_cp, r_am, r_ap;
    logic        r_res_valid;
    logic [31:0] w_draw;
    logic        w_is64;

    assign w_draw = xsh_rr(r_lcg);
    assign w_is64 = (r_act == ACT_DRAW64) || (r_act == ACT_BND64);
    assign o_cmd_ready = (r_state == S_IDLE) && !r_res_valid;
    assign o_res_valid = r_res_valid;
    assign o_res_value = r_val;

    always_comb begin
        o_mac_req.start = 1'b0;
        o_mac_req.a = r_lcg;
        o_mac_req.b = LCG_MULT;
        o_mac_req.c = i_inc;
        case (r_job)
            J_AM:    begin o_mac_req.a = r_am; o_mac_req.b = r_cm; o_mac_req.c = 64'd0; end
            J_AP:    begin o_mac_req.a = r_ap; o_mac_req.b = r_cm; o_mac_req.c = r_cp; end
            J_CP:    begin o_mac_req.a = r_cm + 64'd1; o_mac_req.b = r_cp;
                           o_mac_req.c = 64'd0; end
            J_CM:    begin o_mac_req.a = r_cm; o_mac_req.b = r_cm; o_mac_req.c = 64'd0; end
            J_FIN:   begin o_mac_req.a = r_am; o_mac_req.b = r_lcg; o_mac_req.c = r_ap; end
            default: ;
        endcase
        if ((r_state == S_STEP || r_state == S_ADV || r_state == S_ADVF) && !r_wait)
            o_mac_req.start = 1'b1;
        o_mod_req.start = (r_state == S_THR || r_state == S_RMOD) && !r_modwait;
        // threshold is taken in the width of the bound
        if (r_state == S_THR)
            o_mod_req.num = w_is64 ? (64'd0 - r_bound) : {32'd0, 32'd0 - r_bound[31:0]};
        else
            o_mod_req.num = r_samp;
        o_mod_req.den = r_bound;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_modwait   <= 1'b0;
            r_res_valid <= 1'b0;
            r_lcg       <= 64'd0;
            r_job       <= J_STEP;
        end else begin
            if (r_res_valid && i_res_ready) r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && o_cmd_ready) begin
                        r_act   <= t_action'(i_action);
                        r_val   <= 64'd0;
                        r_samp  <= 64'd0;
                        r_wait  <= 1'b0;
                        r_modwait <= 1'b0;
                        r_reseed_ph <= 1'b0;
                        r_draws <= (t_action'(i_action) == ACT_DRAW64) ? 2'd2 : 2'd1;
                        if (t_action'(i_action) != ACT_ADVANCE) r_job <= J_STEP;
                        else if (i_operand == 64'd0) r_job <= J_FIN;
                        else r_job <= (i_operand[0]) ? J_AM : J_CP;
                        case (t_action'(i_action))
                            ACT_RESEED: begin r_lcg <= 64'd0; r_state <= S_STEP; end
                            ACT_DRAW32, ACT_COIN, ACT_DRAW64: r_state <= S_STEP;
                            ACT_BND32: begin
                                r_bound <= {32'd0, i_operand[31:0]};
                                r_state <= (i_operand[31:0] == 32'd0) ? S_OUT : S_THR;
                            end
                            ACT_BND64: begin
                                r_bound <= i_operand;
                                r_state <= (i_operand == 64'd0) ? S_OUT : S_THR;
                            end
                            ACT_ADVANCE: begin
                                r_dlt <= i_operand; r_cm <= LCG_MULT; r_cp <= i_inc;
                                r_am <= 64'd1; r_ap <= 64'd0;
                                r_state <= (i_operand == 64'd0) ? S_ADVF : S_ADV;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_THR: begin
                    if (!r_modwait) r_modwait <= 1'b1;
                    else if (i_mod_rsp.done) begin
                        r_thr <= i_mod_rsp.res; r_modwait <= 1'b0;
                        r_draws <= w_is64 ? 2'd2 : 2'd1;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (i_mac_rsp.done) begin
                        r_wait <= 1'b0;
                        if (r_act == ACT_RESEED) begin
                            // first phase adds the seed before the final step
                            if (!r_reseed_ph) begin
                                r_lcg <= i_mac_rsp.res + i_seed;
                                r_reseed_ph <= 1'b1;
                            end else begin
                                r_lcg <= i_mac_rsp.res;
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_lcg <= i_mac_rsp.res;
                            if (w_is64 && r_draws == 2'd2)
                                r_samp <= {32'd0, w_draw};
                            else if (w_is64)
                                r_samp <= {w_draw, r_samp[31:0]};
                            else
                                r_samp <= {32'd0, w_draw};
                            r_draws <= r_draws - 2'd1;
                            if (r_draws == 2'd1) begin
                                case (r_act)
                                    ACT_DRAW32: begin r_val <= {32'd0, w_draw};
                                        r_state <= S_OUT; end
                                    ACT_COIN: begin
                                        r_val <= {63'd0, |(w_draw[11:0] & COIN_MASK)};
                                        r_state <= S_OUT;
                                    end
                                    ACT_DRAW64: begin r_val <= {w_draw, r_samp[31:0]};
                                        r_state <= S_OUT; end
                                    default: r_state <= S_RMOD;
                                endcase
                            end
                        end
                    end
                end
                S_RMOD: begin
                    // reject samples below threshold and draw again
                    if (!r_modwait) begin
                        if (r_samp < r_thr) begin
                            r_draws <= w_is64 ? 2'd2 : 2'd1;
                            r_state <= S_STEP;
                        end else r_modwait <= 1'b1;
                    end else if (i_mod_rsp.done) begin
                        r_modwait <= 1'b0;
                        r_val <= i_mod_rsp.res;
                        r_state <= S_OUT;
                    end
                end
                S_ADV: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (i_mac_rsp.done) begin
                        r_wait <= 1'b0;
                        case (r_job)
                            J_AM: begin r_am <= i_mac_rsp.res; r_job <= J_AP; end
                            J_AP: begin r_ap <= i_mac_rsp.res; r_job <= J_CP; end
                            J_CP: begin r_cp <= i_mac_rsp.res; r_job <= J_CM; end
                            default: begin
                                r_cm  <= i_mac_rsp.res;
                                r_dlt <= r_dlt >> 1;
                                if (r_dlt[63:1] == 63'd0) begin
                                    r_job <= J_FIN; r_state <= S_ADVF;
                                end else r_job <= r_dlt[1] ? J_AM : J_CP;
                            end
                        endcase
                    end
                end
                S_ADVF: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (i_mac_rsp.done) begin
                        r_wait <= 1'b0; r_lcg <= i_mac_rsp.res; r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_res_valid) begin
                        r_res_valid <= 1'b1; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PCG_ASSERT_IMPL(a_onehot, 1'b1, $onehot(r_state), "state not one-hot")
    `PCG_ASSERT_NEXT(a_res_hold, r_res_valid && !i_res_ready,
        r_res_valid && $stable(r_val), "result dropped while stalled")
    `PCG_ASSERT_IMPL(a_no_accept_busy, r_state != S_IDLE, !o_cmd_ready,
        "ready while busy")
    `PCG_ASSERT_IMPL(a_unit_excl, o_mac_req.start, !o_mod_req.start,
        "both units started")
endmodule
`default_nettype wire

>>> sv/pcg32_random_engine_top.sv
// Top level of the PCG32 random engine.
// Usage: send one command on the s_axis channel: tuser = action code,
// tdata = 64-bit operand (bound or advance distance). Exactly one 64-bit
// result leaves on m_axis for every command. Registers seed_state (index 0)
// and stream_select (index 1) are written on the cfg channel while idle.
// Each LCG step uses the shared multiply-add unit. Bounded draws add a
// remainder pass for the threshold and one for the final remainder, plus
// one step per 32 bits of each (rejected) draw. Advance costs two
// multiply-adds per bit of the distance up to its top set bit, two more
// for each set bit, plus one.
// One command is in flight at a time; s_axis_tready is low until the result
// is taken. If the receiver stalls, the result holds on m_axis.
// Reset clears the LCG state and both registers to zero.
`default_nettype none
module pcg32_random_engine_top
    import pcg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [63:0] operand
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [63:0] value
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    logic [63:0] r_seed;
    logic [62:0] r_stream;
    t_mac_req    w_mac_req;
    t_mac_rsp    w_mac_rsp;
    t_mod_req    w_mod_req;
    t_mod_rsp    w_mod_rsp;

    // accept register writes only with no command in flight
    assign o_cfg_ready = s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= 64'd0;
            r_stream <= 63'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_SEED) r_seed <= i_cfg_data;
            else if (i_cfg_index == CFG_STREAM) r_stream <= i_cfg_data[62:0];
        end
    end

    pcg_mac u_mac (.i_clk, .i_rst_n, .i_req(w_mac_req), .o_rsp(w_mac_rsp));
    pcg_mod u_mod (.i_clk, .i_rst_n, .i_req(w_mod_req), .o_rsp(w_mod_rsp));

    pcg_seq u_seq (
        .i_clk, .i_rst_n,
        .i_cmd_valid (s_axis_tvalid),
        .o_cmd_ready (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_operand   (s_axis_tdata),
        .i_seed      (r_seed),
        .i_inc       ({r_stream, 1'b1}),
        .o_mac_req   (w_mac_req),
        .i_mac_rsp   (w_mac_rsp),
        .o_mod_req   (w_mod_req),
        .i_mod_rsp   (w_mod_rsp),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res_value (m_axis_tdata)
    );
endmodule
`default_nettype wire
